// ----- rtl/core/ssa_pkg.sv -----
`timescale 1ns / 1ps

package ssa_pkg;

	// defaults for the top-level parameters
	localparam int SLOT_COUNT_DEF       = 8;
	localparam int FRAMES_IN_FLIGHT_DEF = 2;

	// slot numbers are carried at the width of the largest table (64 slots)
	localparam int IDX_W = 6;

	// results per sync command
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		MODE_ACTIVATE   = 2'd0,
		MODE_DEACTIVATE = 2'd1,
		MODE_SYNC       = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	// command token walking down the row of slot cells
	typedef struct packed {
		logic             act;
		mode_t            mode;
		logic [31:0]      id;
		logic             frame;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free_ok;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] n_emit;
		logic             held_v;
		logic [IDX_W-1:0] held_idx;
	} token_t;

	// sync beat released by a cell when it finds the next pending slot
	typedef struct packed {
		logic             strobe;
		logic [IDX_W-1:0] idx;
		logic             frame;
	} flush_t;

	// claim of a free slot, issued after an activate token leaves the row
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      id;
	} grant_t;

endpackage

// ----- rtl/core/ssa_cell.sv -----
`timescale 1ns / 1ps

module ssa_cell #(
	parameter int IDX              = 0,
	parameter int FRAMES_IN_FLIGHT = ssa_pkg::FRAMES_IN_FLIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssa_pkg::token_t tok_in,
	input  ssa_pkg::grant_t grant,
	output ssa_pkg::token_t tok_out,
	output ssa_pkg::flush_t flush
);
	import ssa_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [1:0]       FIF    = 2'(FRAMES_IN_FLIGHT);

	logic [31:0] owner_q;
	logic        valid_q;
	logic [1:0]  pend_q;
	token_t      tok_q;

	logic        match;
	token_t      tok_d;
	logic        valid_d;
	logic [1:0]  pend_d;

	assign match = valid_q && (owner_q == tok_in.id);

	always_comb begin
		tok_d        = tok_in;
		valid_d      = valid_q;
		pend_d       = pend_q;
		flush.strobe = 1'b0;
		flush.idx    = tok_in.held_idx;
		flush.frame  = tok_in.frame;
		if (tok_in.act) begin
			case (tok_in.mode)
				MODE_ACTIVATE: begin
					if (match) begin
						tok_d.hit     = 1'b1;
						tok_d.hit_idx = MY_IDX;
					end
					if (!valid_q && !tok_in.free_ok) begin
						tok_d.free_ok  = 1'b1;
						tok_d.free_idx = MY_IDX;
					end
				end
				MODE_DEACTIVATE: begin
					if (match) begin
						tok_d.hit     = 1'b1;
						tok_d.hit_idx = MY_IDX;
						valid_d       = 1'b0;
						pend_d        = FIF;
					end
				end
				MODE_SYNC: begin
					// emit the previously found slot, keep this one for later
					if (pend_q != 2'd0 && tok_in.n_emit < CNT_W'(MAX_RESULTS)) begin
						pend_d         = pend_q - 2'd1;
						tok_d.n_emit   = tok_in.n_emit + CNT_W'(1);
						flush.strobe   = tok_in.held_v;
						tok_d.held_v   = 1'b1;
						tok_d.held_idx = MY_IDX;
					end
				end
				MODE_CLEAR: begin
					valid_d = 1'b0;
					pend_d  = FIF;
				end
				default: begin
					tok_d = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 2'd0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (grant.en && grant.idx == MY_IDX) begin
				valid_q <= 1'b1;
				pend_q  <= FIF;
			end else begin
				valid_q <= valid_d;
				pend_q  <= pend_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grant.en && grant.idx == MY_IDX) begin
			owner_q <= grant.id;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/core/shadow_slot_allocator.sv -----
`timescale 1ns / 1ps

// shadow slot allocator: a table of SLOT_COUNT slots, one cell per slot
//
// command channel: a beat (mode, owner_id, frame_index) is taken at a rising
// edge with start high and busy low. busy stays high while the command
// token walks the row of cells, one cell per cycle.
// result channel: each result beat is on the result ports for one cycle,
// marked by strobe; last flags the final beat of a command. the receiver
// cannot stall, so beats are never held back.
// results: activate, deactivate and clear give one beat, carried through the
// head register, the cell row and the result register; a command occupies
// the block until its token leaves the cell row. sync beats stream out while
// the token walks (one slot behind the token), the final one at the end,
// at most MAX_RESULTS beats; a sync with nothing pending gives no beat.
// reset: every slot free, every pending count zero; owner ids are only
// compared in valid slots.
module shadow_slot_allocator #(
	parameter int SLOT_COUNT       = ssa_pkg::SLOT_COUNT_DEF,
	parameter int FRAMES_IN_FLIGHT = ssa_pkg::FRAMES_IN_FLIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] owner_id,
	input  logic        frame_index,
	output logic        strobe,
	output logic [2:0]  slot_index,
	output logic        success,
	output logic        already_held,
	output logic        frame_out,
	output logic        last
);
	import ssa_pkg::*;

	logic   busy_q;
	logic   accept;
	token_t head_d;
	token_t head_q;
	token_t tok [SLOT_COUNT+1];
	flush_t flush [SLOT_COUNT];
	flush_t flush_any;
	token_t tail;
	grant_t grant;

	// result register
	logic       strobe_q;
	logic [2:0] slot_q;
	logic       success_q;
	logic       held_q;
	logic       frame_q;
	logic       last_q;

	logic       res_v;
	logic [2:0] res_slot;
	logic       res_ok;
	logic       res_held;
	logic       res_frame;
	logic       res_last;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// head of the row: a fresh token for each accepted command
	always_comb begin
		head_d = '0;
		if (accept) begin
			head_d.act   = 1'b1;
			head_d.mode  = mode_t'(mode);
			head_d.id    = owner_id;
			head_d.frame = frame_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			busy_q <= 1'b0;
		end else begin
			head_q <= head_d;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.act) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok[0] = head_q;

	// row of slot cells, each handing the token to its neighbor
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		ssa_cell #(
			.IDX              (i),
			.FRAMES_IN_FLIGHT (FRAMES_IN_FLIGHT)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.grant   (grant),
			.tok_out (tok[i+1]),
			.flush   (flush[i])
		);
	end

	assign tail = tok[SLOT_COUNT];

	// only the cell holding the token can flush, so an or-merge is enough
	always_comb begin
		flush_any = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			flush_any = flush_any | flush[i];
		end
	end

	// wrap-up once the token leaves the last cell
	always_comb begin
		grant.en  = 1'b0;
		grant.idx = tail.free_idx;
		grant.id  = tail.id;
		res_v     = 1'b0;
		res_slot  = 3'd0;
		res_ok    = 1'b0;
		res_held  = 1'b0;
		res_frame = 1'b0;
		res_last  = 1'b0;
		if (tail.act) begin
			res_last = 1'b1;
			case (tail.mode)
				MODE_ACTIVATE: begin
					res_v = 1'b1;
					if (tail.hit) begin
						res_slot = tail.hit_idx[2:0];
						res_ok   = 1'b1;
						res_held = 1'b1;
					end else if (tail.free_ok) begin
						// claim the lowest free slot seen on the walk
						grant.en = 1'b1;
						res_slot = tail.free_idx[2:0];
						res_ok   = 1'b1;
					end
				end
				MODE_DEACTIVATE: begin
					res_v = 1'b1;
					if (tail.hit) begin
						res_slot = tail.hit_idx[2:0];
						res_ok   = 1'b1;
					end
				end
				MODE_SYNC: begin
					// the slot still held back is the final beat
					res_v     = tail.held_v;
					res_slot  = tail.held_idx[2:0];
					res_ok    = 1'b1;
					res_frame = tail.frame;
				end
				MODE_CLEAR: begin
					res_v  = 1'b1;
					res_ok = 1'b1;
				end
				default: begin
					res_v = 1'b0;
				end
			endcase
		end else if (flush_any.strobe) begin
			// mid-walk sync beat
			res_v     = 1'b1;
			res_slot  = flush_any.idx[2:0];
			res_ok    = 1'b1;
			res_frame = flush_any.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		slot_q    <= res_slot;
		success_q <= res_ok;
		held_q    <= res_held;
		frame_q   <= res_frame;
		last_q    <= res_last;
	end

	assign strobe       = strobe_q;
	assign slot_index   = slot_q;
	assign success      = success_q;
	assign already_held = held_q;
	assign frame_out    = frame_q;
	assign last         = last_q;

endmodule
